FILE: rtl/ffba_pkg.sv
package ffba_pkg;

	// Default number of table entries.
	localparam int unsigned DEFAULT_MAX_BLOCKS = 16;

	// Bytes taken by the header in front of every user area.
	localparam logic [31:0] HEADER_BYTES = 32'd16;

	// Value of the heap limit register after reset.
	localparam logic [31:0] HEAP_LIMIT_RESET = 32'd65536;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_REUSED   = 3'd0,
		STAT_NEW      = 3'd1,
		STAT_MARKED   = 3'd2,
		STAT_RELEASED = 3'd3,
		STAT_ZERO     = 3'd4,
		STAT_NOSPACE  = 3'd5,
		STAT_FULL     = 3'd6,
		STAT_UNKNOWN  = 3'd7
	} status_t;

	// Request kinds.
	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE
	} fsm_state_t;

	// One entry of the block table.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        is_free;
	} entry_t;

endpackage

FILE: rtl/first_fit_block_allocator.sv
// A zero-size allocate gives its result strobe in the cycle after start is taken; any
// other request goes to the decide state, through a table scan unless the table is empty,
// and the strobe is registered from that state. The scan reads at most MAX_BLOCKS entries
// and stops at a hit or at the last entry, set by the one-entry-per-cycle read port of the block table memory.
// Throughput: a new start is taken in the cycle the result strobe is high.
// Reset (arst_n low) empties the table, clears the heap top and sets heap_limit to 65536.
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = DEFAULT_MAX_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] request_size,
	input  logic [31:0] block_address,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] user_address,
	output logic [31:0] granted_size,
	input  logic        heap_limit_we,
	input  logic [31:0] heap_limit_data
);

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

	// Block table memory.
	entry_t mem [MAX_BLOCKS];

	fsm_state_t  state_q, state_nxt;
	logic [31:0] limit_q;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic [31:0] top_q, top_nxt;

	// Request held for the whole operation.
	logic        kind_q;
	logic [31:0] req_q;
	logic [31:0] addr_q;

	// Scan pointer and read pipeline.
	logic [CNT_W-1:0] idx_q;
	logic             rd_v_s1;
	logic [CNT_W-1:0] rd_idx_s1;
	entry_t           rdata_s1;

	// Search result.
	logic             found_q;
	logic [CNT_W-1:0] hit_idx_q;
	entry_t           hit_entry_q;

	// Result registers.
	logic        done_q;
	status_t     status_q, status_nxt;
	logic [31:0] user_q, user_nxt;
	logic [31:0] size_q, size_nxt;

	logic        accept;
	logic        issue;
	logic        fit;
	logic        match;
	logic        hit;
	logic        rd_last;
	logic        mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t      mem_wdata;
	logic [33:0] need;
	logic        full;
	logic        nospace;
	logic        decide_done;

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;

	// Entry checks on the word read from the table.
	assign fit     = rdata_s1.is_free && (rdata_s1.size >= req_q);
	assign match   = ({1'b0, rdata_s1.start} + {1'b0, HEADER_BYTES}) == {1'b0, addr_q};
	assign hit     = rd_v_s1 && ((kind_q == KIND_FREE) ? match : fit);
	assign rd_last = rd_v_s1 && (rd_idx_s1 == (count_q - CNT_W'(1)));
	assign issue   = (state_q == FSM_SCAN) && (idx_q < count_q) && !hit;

	// Space check for a new block at the heap top.
	assign need    = {2'b00, top_q} + {2'b00, HEADER_BYTES} + {2'b00, req_q};
	assign nospace = need > {2'b00, limit_q};
	assign full    = (count_q == CNT_W'(MAX_BLOCKS));

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept && !(kind == KIND_ALLOC && request_size == 32'd0)) begin
					state_nxt = (count_q == '0) ? FSM_DECIDE : FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (hit || rd_last) begin
					state_nxt = FSM_DECIDE;
				end
			end
			FSM_DECIDE: begin
				state_nxt = FSM_IDLE;
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	// Decision and write-back for the finished search.
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = hit_idx_q[IDX_W-1:0];
		mem_wdata  = hit_entry_q;
		count_nxt  = count_q;
		top_nxt    = top_q;
		status_nxt = STAT_UNKNOWN;
		user_nxt   = '0;
		size_nxt   = '0;
		if (kind_q == KIND_ALLOC) begin
			if (found_q) begin
				mem_we            = 1'b1;
				mem_wdata.is_free = 1'b0;
				status_nxt        = STAT_REUSED;
				user_nxt          = hit_entry_q.start + HEADER_BYTES;
				size_nxt          = hit_entry_q.size;
			end else if (full) begin
				status_nxt = STAT_FULL;
			end else if (nospace) begin
				status_nxt = STAT_NOSPACE;
			end else begin
				mem_we            = 1'b1;
				mem_waddr         = count_q[IDX_W-1:0];
				mem_wdata.start   = top_q;
				mem_wdata.size    = req_q;
				mem_wdata.is_free = 1'b0;
				count_nxt         = count_q + CNT_W'(1);
				top_nxt           = need[31:0];
				status_nxt        = STAT_NEW;
				user_nxt          = top_q + HEADER_BYTES;
				size_nxt          = req_q;
			end
		end else if (found_q && !hit_entry_q.is_free) begin
			size_nxt = hit_entry_q.size;
			if (hit_idx_q == (count_q - CNT_W'(1))) begin
				count_nxt  = hit_idx_q;
				top_nxt    = hit_entry_q.start;
				status_nxt = STAT_RELEASED;
			end else begin
				mem_we            = 1'b1;
				mem_wdata.is_free = 1'b1;
				status_nxt        = STAT_MARKED;
			end
		end
	end

	assign decide_done = (state_q == FSM_DECIDE);

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (decide_done && mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[idx_q[IDX_W-1:0]];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= HEAP_LIMIT_RESET;
			count_q <= '0;
			top_q   <= '0;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (heap_limit_we) begin
				limit_q <= heap_limit_data;
			end
			rd_v_s1 <= issue;
			done_q  <= decide_done || (accept && kind == KIND_ALLOC && request_size == 32'd0);
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (decide_done) begin
				count_q <= count_nxt;
				top_q   <= top_nxt;
			end
		end
	end

	// Request, search and result payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			kind_q <= kind;
			req_q  <= request_size;
			addr_q <= block_address;
		end
		if (hit) begin
			hit_idx_q   <= rd_idx_s1;
			hit_entry_q <= rdata_s1;
		end
		if (decide_done) begin
			status_q <= status_nxt;
			user_q   <= user_nxt;
			size_q   <= size_nxt;
		end else if (accept) begin
			status_q <= STAT_ZERO;
			user_q   <= '0;
			size_q   <= '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign user_address = user_q;
	assign granted_size = size_q;

	// The table never holds more entries than it has room for.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count above table depth");

	// A new block adds exactly one table entry.
	a_new_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STAT_NEW) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("new block did not grow the table");

	// Only granted blocks carry a user address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != STAT_REUSED && status_q != STAT_NEW) |-> (user_q == '0))
		else $error("user address set without a grant");

	// A taken request either starts work or finishes at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q))
		else $error("accepted request dropped");

	// The heap top only moves when an operation completes.
	a_top_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!decide_done |=> $stable(top_q))
		else $error("heap top moved outside write-back");

endmodule

FILE: sim/tb_first_fit_block_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
	import ffba_pkg::*;

	localparam int unsigned TABLE_DEPTH = DEFAULT_MAX_BLOCKS;
	localparam int unsigned WATCHDOG_CYCLES = 5000;

	// One response beat as the allocator should produce it.
	typedef struct {
		status_t     status;
		logic [31:0] user_address;
		logic [31:0] granted_size;
	} response_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [31:0] request_size;
	logic [31:0] block_address;
	logic        done;
	logic [2:0]  status;
	logic [31:0] user_address;
	logic [31:0] granted_size;
	logic        heap_limit_we;
	logic [31:0] heap_limit_data;

	// Shadow copy of the heap: block table, heap top and limit.
	logic [31:0] blk_start [TABLE_DEPTH];
	logic [31:0] blk_size [TABLE_DEPTH];
	bit          blk_free [TABLE_DEPTH];
	int unsigned blk_count;
	logic [31:0] heap_top_model;
	logic [31:0] heap_limit_model;

	response_t   pending_responses [$];
	int unsigned errors;
	int unsigned quiet_cycles;
	int unsigned burst_left;

	first_fit_block_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.request_size   (request_size),
		.block_address  (block_address),
		.done           (done),
		.status         (status),
		.user_address   (user_address),
		.granted_size   (granted_size),
		.heap_limit_we  (heap_limit_we),
		.heap_limit_data(heap_limit_data)
	);

	// 12 ns clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Applies one request to the shadow heap and returns the response it must produce.
	function automatic response_t apply_request(kind_t k, logic [31:0] size, logic [31:0] addr);
		response_t   r;
		logic [32:0] need;
		bit          found;
		int unsigned hit;
		r.status = STAT_UNKNOWN;
		r.user_address = '0;
		r.granted_size = '0;
		found = 1'b0;
		hit = 0;
		if (k == KIND_ALLOC) begin
			if (size == '0) begin
				r.status = STAT_ZERO;
			end else begin
				// First fit over the existing blocks, no splitting.
				for (int unsigned i = 0; i < blk_count; i++) begin
					if (!found && blk_free[i] && blk_size[i] >= size) begin
						found = 1'b1;
						blk_free[i] = 1'b0;
						r.status = STAT_REUSED;
						r.user_address = blk_start[i] + HEADER_BYTES;
						r.granted_size = blk_size[i];
					end
				end
				if (!found) begin
					need = {1'b0, heap_top_model} + HEADER_BYTES + size;
					if (blk_count >= TABLE_DEPTH) begin
						r.status = STAT_FULL;
					end else if (need > {1'b0, heap_limit_model}) begin
						r.status = STAT_NOSPACE;
					end else begin
						blk_start[blk_count] = heap_top_model;
						blk_size[blk_count] = size;
						blk_free[blk_count] = 1'b0;
						blk_count++;
						heap_top_model = need[31:0];
						r.status = STAT_NEW;
						r.user_address = blk_start[blk_count - 1] + HEADER_BYTES;
						r.granted_size = size;
					end
				end
			end
		end else begin
			// Look up the block whose user area starts at the given offset.
			for (int unsigned i = 0; i < blk_count; i++) begin
				if (!found && ({1'b0, blk_start[i]} + HEADER_BYTES) == {1'b0, addr}) begin
					found = 1'b1;
					hit = i;
				end
			end
			if (!found || blk_free[hit]) begin
				r.status = STAT_UNKNOWN;
			end else if (hit + 1 == blk_count) begin
				heap_top_model = blk_start[hit];
				blk_count = hit;
				r.status = STAT_RELEASED;
				r.granted_size = blk_size[hit];
			end else begin
				blk_free[hit] = 1'b1;
				r.status = STAT_MARKED;
				r.granted_size = blk_size[hit];
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] live_address(int unsigned idx);
		return blk_start[idx] + HEADER_BYTES;
	endfunction

	// Sends one request beat; the sender runs in bursts with random gaps between them.
	task automatic send_request(kind_t k, logic [31:0] size, logic [31:0] addr);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		kind <= k;
		request_size <= size;
		block_address <= addr;
		do @(posedge clk); while (busy);
		pending_responses.push_back(apply_request(k, size, addr));
	endtask

	task automatic request_alloc(logic [31:0] size);
		send_request(KIND_ALLOC, size, $urandom);
	endtask

	task automatic request_free(logic [31:0] addr);
		send_request(KIND_FREE, $urandom, addr);
	endtask

	// Holds the sender off until every outstanding response has arrived.
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
	endtask

	task automatic write_heap_limit(logic [31:0] value);
		wait_idle();
		@(negedge clk);
		heap_limit_we <= 1'b1;
		heap_limit_data <= value;
		@(negedge clk);
		heap_limit_we <= 1'b0;
		heap_limit_data <= $urandom;
		heap_limit_model = value;
	endtask

	// Empties the table: reuse free entries so that every block can be popped from the top.
	task automatic empty_heap();
		bit any_free;
		while (blk_count > 0) begin
			any_free = 1'b0;
			for (int unsigned i = 0; i < blk_count; i++) begin
				if (blk_free[i])
					any_free = 1'b1;
			end
			if (any_free)
				request_alloc(1);
			else
				request_free(live_address(blk_count - 1));
		end
	endtask

	// Zero size, unknown and double frees, reuse without split, and trailing free blocks.
	task automatic test_special_cases();
		request_alloc(0);
		request_free(32'h0000_0000);
		request_free(32'hFFFF_FFFF);
		request_alloc(32'hFFFF_FFFF);
		request_alloc(100);
		request_alloc(1);
		request_alloc(8);
		request_free(16);
		request_free(16);
		request_alloc(50);
		request_free(live_address(1));
		request_free(live_address(2));
		request_free(live_address(1) + 1);
		request_alloc(1);
	endtask

	// Fill the table, then check that a full table still allows reuse.
	task automatic test_table_full();
		while (blk_count < TABLE_DEPTH)
			request_alloc($urandom_range(1, 32));
		request_alloc(32'h0010_0000);
		request_free(live_address(TABLE_DEPTH / 2));
		request_alloc(1);
		request_alloc(32'h0010_0000);
		request_free(live_address(blk_count - 1));
		request_alloc(40000);
	endtask

	// Smallest and largest heap limits, with exact fits and sums that pass 32 bits.
	task automatic test_limit_extremes();
		empty_heap();
		write_heap_limit(32'd16);
		request_alloc(1);
		request_alloc(0);
		write_heap_limit(32'd17);
		request_alloc(1);
		request_alloc(1);
		request_free(16);
		write_heap_limit(32'hFFFF_FFFF);
		request_alloc(32'hFFFF_FFEF);
		request_alloc(1);
		request_free(16);
		request_alloc(32'hFFFF_FFFF);
		request_alloc(32'hFFFF_FFF0);
	endtask

	// Mostly well-formed traffic: allocations of varied sizes and frees of live blocks.
	task automatic test_random_traffic(int unsigned count, logic [31:0] limit);
		int unsigned roll;
		int unsigned pick;
		logic [31:0] size;
		write_heap_limit(limit);
		repeat (count) begin
			if ($urandom_range(0, 49) == 0)
				wait_idle();
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					size = '0;
				else if (pick < 65)
					size = $urandom_range(1, 64);
				else if (pick < 90)
					size = $urandom_range(65, 4096);
				else
					size = $urandom;
				request_alloc(size);
			end else if (roll < 85) begin
				if (blk_count > 0)
					request_free(live_address($urandom_range(0, blk_count - 1)));
				else
					request_free(16);
			end else if (roll < 95 && blk_count > 0) begin
				request_free(live_address(blk_count - 1));
			end else begin
				// Stray addresses: fully random, just past the start of a user area, or zero.
				pick = $urandom_range(0, 2);
				if (pick == 0 || blk_count == 0)
					request_free($urandom);
				else if (pick == 1)
					request_free(live_address($urandom_range(0, blk_count - 1))
						+ $urandom_range(1, 15));
				else
					request_free('0);
			end
		end
	endtask

	// Compare every response beat against the oldest prediction.
	always @(posedge clk) begin : check_responses
		response_t want;
		if (arst_n && done) begin
			if (pending_responses.size() == 0) begin
				$error("unexpected response: status %0d, user_address %0h, granted_size %0h",
					status, user_address, granted_size);
				errors++;
			end else begin
				want = pending_responses.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (user_address !== want.user_address) begin
					$error("user_address: expected %0h, got %0h", want.user_address,
						user_address);
					errors++;
				end
				if (granted_size !== want.granted_size) begin
					$error("granted_size: expected %0h, got %0h", want.granted_size,
						granted_size);
					errors++;
				end
			end
		end
	end

	// Stop the run if neither a request nor a response moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("tb_first_fit_block_allocator: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_ALLOC;
		request_size = '0;
		block_address = '0;
		heap_limit_we = 1'b0;
		heap_limit_data = '0;
		errors = 0;
		quiet_cycles = 0;
		burst_left = 0;
		blk_count = 0;
		heap_top_model = '0;
		heap_limit_model = HEAP_LIMIT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_special_cases();
		test_table_full();
		test_limit_extremes();
		test_random_traffic(200, HEAP_LIMIT_RESET);
		test_random_traffic(200, $urandom_range(200, 3000));
		test_random_traffic(200, 32'hFFFF_FFFF);
		test_random_traffic(200, $urandom_range(16, 32'hFFFF_FFFF));
		test_random_traffic(200, $urandom_range(16, 600));
		test_random_traffic(200, HEAP_LIMIT_RESET);

		wait_idle();
		repeat (40) @(posedge clk);
		if (pending_responses.size() != 0) begin
			$error("%0d responses never arrived", pending_responses.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_first_fit_block_allocator: PASS");
		else
			$display("tb_first_fit_block_allocator: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator.sv
sim/tb_first_fit_block_allocator.sv
